[rtl/core/pgwalk_pkg.sv]
package pgwalk_pkg;

   localparam int VaWidth    = 48;
   localparam int PaWidth    = 52;
   localparam int EntryWidth = 64;
   localparam int IdxWidth   = 9;

   localparam int ReqDataWidth = 112;
   localparam int RspDataWidth = 112;

   // Input word kinds carried in tuser.
   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_READ_RSP  = 1'b1;

   // Result word kinds carried in tuser.
   localparam logic RSP_READ_REQ = 1'b0;
   localparam logic RSP_FINISHED = 1'b1;

   localparam logic [1:0] LEVEL_TOP    = 2'd0;
   localparam logic [1:0] LEVEL_SECOND = 2'd1;
   localparam logic [1:0] LEVEL_THIRD  = 2'd2;
   localparam logic [1:0] LEVEL_LEAF   = 2'd3;

   localparam int LargePageBit = 7;

   typedef struct packed {
      logic               kind;
      logic [PaWidth-1:0] read_addr;
      logic [PaWidth-1:0] phys_addr;
      logic               fault;
   } result_type;

endpackage

[rtl/core/four_level_page_table_walker_core.sv]
// A result is registered in the head entry, or the skid entry when the head stalls.
// Throughput: one input word per cycle; a two-entry output stage keeps accepting
// while a result waits, and req_tready drops only when both entries are full.
// Input words that cause no result are accepted under the same condition.
// Reset (synchronous, active high) clears the walk state, table_root and both
// output entries; the block is idle afterwards.
module four_level_page_table_walker_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [pgwalk_pkg::PaWidth-1:0]       csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: virt_addr[47:0], read_data[111:48]
   input  logic [pgwalk_pkg::ReqDataWidth-1:0]  req_tdata,
   // tuser: req_type[0]
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: read_addr[51:0], phys_addr[103:52], fault[104], zero[111:105]
   output logic [pgwalk_pkg::RspDataWidth-1:0]  rsp_tdata,
   // tuser: result_kind[0]
   output logic [0:0]                           rsp_tuser
);

   logic [pgwalk_pkg::PaWidth-1:0]  table_root_ff;
   logic                            busy_ff, busy_in;
   logic [1:0]                      level_ff, level_in;
   logic [pgwalk_pkg::VaWidth-1:0]  vaddr_ff, vaddr_in;

   logic                            out_valid_ff, out_valid_in;
   pgwalk_pkg::result_type          out_ff, out_in;
   logic                            skid_valid_ff, skid_valid_in;
   pgwalk_pkg::result_type          skid_ff, skid_in;

   logic                               accept;
   logic                               res_valid;
   pgwalk_pkg::result_type             res;
   logic [pgwalk_pkg::VaWidth-1:0]     in_vaddr;
   logic [pgwalk_pkg::EntryWidth-1:0]  in_entry;
   logic [pgwalk_pkg::IdxWidth-1:0]    next_idx;
   logic                               out_taken;

   assign in_vaddr = req_tdata[pgwalk_pkg::VaWidth-1:0];
   assign in_entry = req_tdata[pgwalk_pkg::VaWidth +: pgwalk_pkg::EntryWidth];
   assign accept   = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign out_taken  = out_valid_ff && rsp_tready;

   // Index of the next table, taken from the held address.
   always_comb begin
      case (level_ff)
         pgwalk_pkg::LEVEL_TOP:    next_idx = vaddr_ff[38:30];
         pgwalk_pkg::LEVEL_SECOND: next_idx = vaddr_ff[29:21];
         default:                  next_idx = vaddr_ff[20:12];
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      level_in  = level_ff;
      vaddr_in  = vaddr_ff;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         if (req_tuser[0] == pgwalk_pkg::REQ_TRANSLATE) begin
            if (!busy_ff) begin
               busy_in       = 1'b1;
               level_in      = pgwalk_pkg::LEVEL_TOP;
               vaddr_in      = in_vaddr;
               res_valid     = 1'b1;
               res.kind      = pgwalk_pkg::RSP_READ_REQ;
               res.read_addr = {table_root_ff[51:12], in_vaddr[47:39], 3'b000};
            end
         end else if (busy_ff) begin
            res_valid = 1'b1;
            if (in_entry == '0) begin
               busy_in   = 1'b0;
               level_in  = pgwalk_pkg::LEVEL_TOP;
               res.kind  = pgwalk_pkg::RSP_FINISHED;
               res.fault = 1'b1;
            end else if (level_ff == pgwalk_pkg::LEVEL_THIRD &&
                         in_entry[pgwalk_pkg::LargePageBit]) begin
               busy_in       = 1'b0;
               level_in      = pgwalk_pkg::LEVEL_TOP;
               res.kind      = pgwalk_pkg::RSP_FINISHED;
               res.phys_addr = {in_entry[51:21], vaddr_ff[20:0]};
            end else if (level_ff == pgwalk_pkg::LEVEL_LEAF) begin
               busy_in       = 1'b0;
               level_in      = pgwalk_pkg::LEVEL_TOP;
               res.kind      = pgwalk_pkg::RSP_FINISHED;
               res.phys_addr = {in_entry[51:12], vaddr_ff[11:0]};
            end else begin
               level_in      = level_ff + 2'd1;
               res.kind      = pgwalk_pkg::RSP_READ_REQ;
               res.read_addr = {in_entry[51:12], next_idx, 3'b000};
            end
         end
      end
   end

   // Two-entry output stage: the skid entry catches a result while the
   // head entry is stalled, and drains into the head once it is taken.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_taken || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = res_valid;
            skid_in       = res;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff <= '0;
         busy_ff       <= 1'b0;
         level_ff      <= pgwalk_pkg::LEVEL_TOP;
         vaddr_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            table_root_ff <= csr_wdata;
         end
         busy_ff       <= busy_in;
         level_ff      <= level_in;
         vaddr_ff      <= vaddr_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_ff.kind;
   assign rsp_tdata    = {7'b0, out_ff.fault, out_ff.phys_addr, out_ff.read_addr};

   a_skid_needs_head : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the head entry is empty");

   a_idle_level : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> level_ff == pgwalk_pkg::LEVEL_TOP)
      else $error("walk level is not cleared while idle");

   a_finish_goes_idle : assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == pgwalk_pkg::RSP_FINISHED) |=> !busy_ff)
      else $error("walker still busy after a finished translation");

   a_start_goes_busy : assert property (@(posedge clock) disable iff (reset)
      (accept && !busy_ff && req_tuser[0] == pgwalk_pkg::REQ_TRANSLATE) |=>
      (busy_ff && (out_valid_ff || skid_valid_ff)))
      else $error("translate request did not start a walk");

   a_fault_clean : assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.fault) |-> (res.phys_addr == '0 && res.read_addr == '0))
      else $error("fault result carries an address");

endmodule

[verif/tb_four_level_page_table_walker_core.sv]
module tb_four_level_page_table_walker_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit  = 4000;
   localparam int HoldCycles  = 120;
   localparam int PhaseWords  = 174;
   localparam int ReportLimit = 10;

   class walk_tracker;
      logic [pgwalk_pkg::PaWidth-1:0] root    = '0;
      bit                             walking = 1'b0;
      logic [1:0]                     level   = pgwalk_pkg::LEVEL_TOP;
      logic [pgwalk_pkg::VaWidth-1:0] vaddr   = '0;
      pgwalk_pkg::result_type         due_q[$];
      time                            due_at[$];
      int failures, checked, walks, faults, big_pages, small_pages, ignored;

      // Entry address for the held virtual address within one table level.
      function logic [pgwalk_pkg::PaWidth-1:0] entry_addr(
            logic [pgwalk_pkg::PaWidth-1:0] table_base, logic [1:0] lvl);
         logic [pgwalk_pkg::VaWidth-1:0] shifted;
         shifted = vaddr >> (39 - 9 * int'(lvl));
         return {table_base[pgwalk_pkg::PaWidth-1:12], 12'h000} +
                {shifted[pgwalk_pkg::IdxWidth-1:0], 3'b000};
      endfunction

      // Advances the walk by one accepted input word; returns 1 when a result word is due.
      function bit note_word(logic kind, logic [pgwalk_pkg::VaWidth-1:0] va,
                             logic [pgwalk_pkg::EntryWidth-1:0] entry);
         pgwalk_pkg::result_type r;
         r = '0;
         if (kind == pgwalk_pkg::REQ_TRANSLATE) begin
            if (walking) begin
               ignored++;
               return 1'b0;
            end
            walking = 1'b1;
            level   = pgwalk_pkg::LEVEL_TOP;
            vaddr   = va;
            walks++;
            r.kind      = pgwalk_pkg::RSP_READ_REQ;
            r.read_addr = entry_addr(root, pgwalk_pkg::LEVEL_TOP);
         end else if (!walking) begin
            ignored++;
            return 1'b0;
         end else if (entry == '0) begin
            walking = 1'b0;
            level   = pgwalk_pkg::LEVEL_TOP;
            faults++;
            r.kind  = pgwalk_pkg::RSP_FINISHED;
            r.fault = 1'b1;
         end else if (level == pgwalk_pkg::LEVEL_THIRD && entry[pgwalk_pkg::LargePageBit]) begin
            walking = 1'b0;
            level   = pgwalk_pkg::LEVEL_TOP;
            big_pages++;
            r.kind      = pgwalk_pkg::RSP_FINISHED;
            r.phys_addr = {entry[pgwalk_pkg::PaWidth-1:21], 21'h0} + vaddr[20:0];
         end else if (level == pgwalk_pkg::LEVEL_LEAF) begin
            walking = 1'b0;
            level   = pgwalk_pkg::LEVEL_TOP;
            small_pages++;
            r.kind      = pgwalk_pkg::RSP_FINISHED;
            r.phys_addr = {entry[pgwalk_pkg::PaWidth-1:12], 12'h000} + vaddr[11:0];
         end else begin
            level       = level + 2'd1;
            r.kind      = pgwalk_pkg::RSP_READ_REQ;
            r.read_addr = entry_addr(entry[pgwalk_pkg::PaWidth-1:0], level);
         end
         due_q.push_back(r);
         due_at.push_back($time);
         return 1'b1;
      endfunction

      function void report_failure(string what);
         failures++;
         if (failures <= ReportLimit) begin
            $display("%0t: %s", $time, what);
         end
      endfunction

      function void check_word(logic kind, logic [pgwalk_pkg::RspDataWidth-1:0] data);
         pgwalk_pkg::result_type got, want;
         got.kind      = kind;
         got.read_addr = data[pgwalk_pkg::PaWidth-1:0];
         got.phys_addr = data[2*pgwalk_pkg::PaWidth-1:pgwalk_pkg::PaWidth];
         got.fault     = data[2*pgwalk_pkg::PaWidth];
         checked++;
         // An expectation noted at this very edge cannot be answered yet.
         if (due_q.size() == 0 || due_at[0] == $time) begin
            report_failure($sformatf({"unexpected result word: kind %0d read_addr %h ",
                                      "phys_addr %h fault %0d"},
                                     got.kind, got.read_addr, got.phys_addr, got.fault));
            return;
         end
         want = due_q.pop_front();
         void'(due_at.pop_front());
         if (got.kind !== want.kind || got.read_addr !== want.read_addr ||
             got.phys_addr !== want.phys_addr || got.fault !== want.fault ||
             data[pgwalk_pkg::RspDataWidth-1:2*pgwalk_pkg::PaWidth+1] !== '0) begin
            report_failure($sformatf({"result word mismatch: expected kind %0d read_addr %h ",
                                      "phys_addr %h fault %0d, got kind %0d read_addr %h ",
                                      "phys_addr %h fault %0d pad %h"},
                                     want.kind, want.read_addr, want.phys_addr, want.fault,
                                     got.kind, got.read_addr, got.phys_addr, got.fault,
                                     data[pgwalk_pkg::RspDataWidth-1:2*pgwalk_pkg::PaWidth+1]));
         end
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                csr_wen    = 1'b0;
   logic [pgwalk_pkg::PaWidth-1:0]      csr_wdata  = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [pgwalk_pkg::ReqDataWidth-1:0] req_tdata  = '0;
   logic [0:0]                          req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [pgwalk_pkg::RspDataWidth-1:0] rsp_tdata;
   logic [0:0]                          rsp_tuser;

   walk_tracker tracker = new();
   int tx_idle_pct   = 7;
   int rx_idle_pct   = 49;
   bit stall_request = 1'b0;
   int result_words  = 0;
   int root_writes   = 0;

   four_level_page_table_walker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, and on request one long hold-off so the block backs up.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         tracker.check_word(rsp_tuser[0], rsp_tdata);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_word(logic kind, logic [pgwalk_pkg::VaWidth-1:0] va,
                            logic [pgwalk_pkg::EntryWidth-1:0] entry);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {entry, va};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (tracker.note_word(kind, va, entry)) begin
         result_words++;
      end
   endtask

   // The field that the word kind does not use carries random junk.
   task automatic translate(logic [pgwalk_pkg::VaWidth-1:0] va);
      send_word(pgwalk_pkg::REQ_TRANSLATE, va, {$urandom, $urandom});
   endtask

   task automatic read_rsp(logic [pgwalk_pkg::EntryWidth-1:0] entry);
      send_word(pgwalk_pkg::REQ_READ_RSP, {16'($urandom), 32'($urandom)}, entry);
   endtask

   task automatic drain_walker();
      req_tvalid <= 1'b0;
      while (tracker.due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_root(logic [pgwalk_pkg::PaWidth-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      tracker.root = value;
      root_writes++;
   endtask

   function automatic logic [pgwalk_pkg::VaWidth-1:0] random_vaddr();
      case ($urandom_range(19))
         0: return '0;
         1: return '1;
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   // Table entries: mostly random, with zero entries, all-ones entries, entries whose
   // only set bits lie above the address field, and a biased large-page bit at level 2.
   function automatic logic [pgwalk_pkg::EntryWidth-1:0] random_entry(logic [1:0] lvl);
      logic [pgwalk_pkg::EntryWidth-1:0] e;
      int pick;
      pick = $urandom_range(99);
      e    = {$urandom, $urandom};
      if (pick < 7) begin
         e = '0;
      end else if (pick < 11) begin
         e = '1;
      end else if (pick < 14) begin
         e = 64'd1 << $urandom_range(63, 52);
      end else if (lvl == pgwalk_pkg::LEVEL_THIRD) begin
         e[pgwalk_pkg::LargePageBit] = (pick < 52);
      end
      return e;
   endfunction

   initial begin
      logic [pgwalk_pkg::PaWidth-1:0] roots [6];
      int goal;
      bit held;
      roots[0] = '0;
      roots[1] = {20'($urandom), 32'($urandom)};
      roots[2] = 52'h0_0000_0000_1000;
      roots[3] = {20'($urandom), 32'($urandom)} | 52'hFFF;
      roots[4] = '1;
      roots[5] = {20'($urandom), 32'($urandom)};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The low twelve bits of the root must never show up in a read address.
      write_root('1);
      translate(48'h0);
      read_rsp(64'h0);                          // zero entry at the top level
      translate('1);
      translate(48'h1234_5678_9ABC);            // dropped, a walk is under way
      read_rsp('1);                             // large-page bit at top and second level
      read_rsp('1);                             // is ignored; at the third it maps 2 MiB
      read_rsp('1);
      read_rsp(64'h0);                          // response with no walk under way
      translate(48'h8000_0000_0FFF);
      read_rsp(64'h0000_0000_0000_1000);
      read_rsp(64'h000F_FFFF_FFFF_F000);
      read_rsp(64'h8000_0000_0000_007F);
      read_rsp(64'hFFF0_0000_0000_0080);        // large-page bit on a leaf is ignored
      translate(48'h7FFF_FFFF_F000);
      read_rsp(64'h1);
      read_rsp(64'h2);
      read_rsp(64'h0);                          // zero entry at the third level
      translate(48'h0000_0040_0000);
      read_rsp(64'h0000_0000_0ABC_D000);
      read_rsp(64'h0000_0000_0000_0100);
      read_rsp(64'h0000_0012_3456_7000);
      read_rsp(64'h0);                          // zero entry at the leaf
      drain_walker();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               tx_idle_pct = 7;
               rx_idle_pct = 49;
            end
            1: begin
               tx_idle_pct = 49;
               rx_idle_pct = 7;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         write_root(roots[phase]);
         goal = result_words + PhaseWords;
         held = 1'b0;
         while (result_words < goal) begin
            if (phase % 3 == 0 && !held && result_words >= goal - PhaseWords / 2) begin
               stall_request = 1'b1;
               held          = 1'b1;
            end
            if (!tracker.walking) begin
               if ($urandom_range(99) < 88) begin
                  translate(random_vaddr());
               end else begin
                  read_rsp(random_entry(tracker.level));
               end
            end else if ($urandom_range(99) < 92) begin
               read_rsp(random_entry(tracker.level));
            end else begin
               translate(random_vaddr());
            end
         end
         drain_walker();
      end

      if (tracker.due_q.size() != 0) begin
         tracker.report_failure($sformatf("%0d expected result words never arrived",
                                          tracker.due_q.size()));
      end
      $display({"Walks started: %0d; 4 KiB pages %0d, 2 MiB pages %0d, faults %0d; ",
                "%0d words ignored."},
               tracker.walks, tracker.small_pages, tracker.big_pages, tracker.faults,
               tracker.ignored);
      $display("Result words checked: %0d across %0d root settings; failures: %0d.",
               tracker.checked, root_writes, tracker.failures);
      if (tracker.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
